FILE: src/multi_mode_adc_channel_filter_assert.svh
// Assertion macros for the multi-mode ADC channel filter.
// Used by the top level only; no dependencies.
`ifndef MULTI_MODE_ADC_CHANNEL_FILTER_ASSERT_SVH
`define MULTI_MODE_ADC_CHANNEL_FILTER_ASSERT_SVH
// Implication checked on every clock outside reset.
`define MMF_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication.
`define MMF_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

FILE: src/mmf_pkg.sv
// Package for the multi-mode ADC channel filter.
// Constants, types and the sequencer state encoding; no dependencies.
`timescale 1ns / 1ps
package mmf_pkg;
  localparam int NCH = 6;
  localparam int AVG_WINDOW = 8;
  localparam int AVG_W = $clog2(AVG_WINDOW);
  localparam int AVG_DEPTH = AVG_WINDOW * NCH;
  localparam int AVG_AW = $clog2(AVG_DEPTH);
  localparam int CH_W = 3;
  localparam logic [19:0] KAL_EST_RESET = 20'd524288;
  localparam logic [19:0] KAL_COV_RESET = 20'd65536;
  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_AVG = 2'd1;
  localparam logic [1:0] MODE_MED = 2'd2;
  localparam logic [1:0] MODE_KAL = 2'd3;
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_Q = 2'd1;
  localparam logic [1:0] REG_R = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CLEAR = 11'b00000000010,
    S_RD    = 11'b00000000100,
    S_AVG   = 11'b00000001000,
    S_DIV   = 11'b00000010000,
    S_KP    = 11'b00000100000,
    S_KDIV  = 11'b00001000000,
    S_KM1   = 11'b00010000000,
    S_KM2   = 11'b00100000000,
    S_NEXT  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;
endpackage

FILE: src/mmf_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module mmf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: src/multi_mode_adc_channel_filter.sv
// Top level of the six-channel multi-mode ADC filter.
// Uses mmf_pkg, mmf_ram and the assertion macro header.
//
// Usage: s_axis carries one frame of six 12-bit samples per request
// (tdata bits [71:0], channel 0 lowest). m_axis returns one request per
// frame: six 12-bit filtered values in tdata[71:0], ready flag in tuser.
// cfg writes: index 0 mode (clears all filter state), 1 Q, 2 R.
// Processing: one frame is handled channel by channel through a shared
// unit. Per channel, average mode runs 18 divider steps and Kalman 37
// divider steps (none when the gain denominator is zero); other modes
// use no divider. After the last channel the result is flagged valid.
// A new frame is not accepted until the last is done and its result taken;
// the 37-step restoring divider for the Kalman gain sets the worst case.
// After reset, or a mode write, a clearing pass over all 48 entries zeroes the
// average ring; input is not accepted meanwhile (config is).
// The output register holds a result until m_axis_tready; s_axis_tready
// stays low until the previous result has been taken.
`timescale 1ns / 1ps
`include "multi_mode_adc_channel_filter_assert.svh"
module multi_mode_adc_channel_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // sample_ch0..sample_ch5
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // filtered_ch0..filtered_ch5
  output logic        m_axis_tuser,  // ready_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  mmf_pkg::state_t state;
  logic [1:0]  mode;
  logic [19:0] q_noise, r_noise;
  logic [71:0] samp;
  logic [11:0] res [mmf_pkg::NCH];
  logic [2:0]  ch;
  logic [17:0] sums [mmf_pkg::NCH];
  logic [mmf_pkg::AVG_W-1:0] slot;
  logic [3:0]  fill;
  logic [11:0] med [3][mmf_pkg::NCH];
  logic [1:0]  mslot, mfill;
  logic [19:0] est [mmf_pkg::NCH];
  logic [19:0] cov [mmf_pkg::NCH];
  logic        rdy;
  logic [mmf_pkg::AVG_AW-1:0] clr_cnt;
  logic        out_v;
  // shared divider
  logic [36:0] dnum;
  logic [20:0] drem, dden;
  logic [5:0]  dcnt;
  logic [20:0] p1;
  logic [16:0] kgain;
  logic signed [21:0] diff;
  logic signed [39:0] prod;
  logic [36:0] pcov;

  logic        ram_we;
  logic [mmf_pkg::AVG_AW-1:0] ram_wa, ram_ra;
  logic [11:0] ram_wd, ram_rd;
  logic [11:0] z;
  logic        cfg_fire, in_fire, mode_wr;
  logic [21:0] rem_try;
  logic [20:0] p1_sum;
  logic [21:0] den_sum;
  logic signed [22:0] xnew;
  logic signed [39:0] corr;
  logic [11:0] m0, m1, m2, mlo, mhi;

  assign cfg_ready = 1'b1;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign mode_wr = cfg_fire && cfg_index == mmf_pkg::REG_MODE;
  assign s_axis_tready = state == mmf_pkg::S_IDLE && !out_v && !mode_wr;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_v;
  assign z = samp[12*ch +: 12];
  // ring address = slot * 6 + ch
  assign ram_ra = mmf_pkg::AVG_AW'({1'b0, slot, 2'b00} + {2'b00, slot, 1'b0} + {3'b000, ch});

  always_comb begin
    ram_we = 1'b0;
    ram_wa = ram_ra;
    ram_wd = z;
    if (state == mmf_pkg::S_CLEAR) begin
      ram_we = 1'b1;
      ram_wa = clr_cnt;
      ram_wd = '0;
    end else if (state == mmf_pkg::S_AVG) begin
      ram_we = 1'b1;
    end
  end

  mmf_ram #(.WIDTH(12), .DEPTH(mmf_pkg::AVG_DEPTH)) u_ring (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  always_comb begin
    rem_try = {drem, dnum[36]} - {1'b0, dden};
    p1_sum = 21'(cov[ch]) + 21'(q_noise);
    den_sum = 22'(p1) + 22'(r_noise);
    corr = prod >>> 16;
    xnew = 23'(signed'({3'b000, est[ch]})) + 23'(corr);
    m0 = med[0][ch];
    m1 = med[1][ch];
    m2 = med[2][ch];
    mlo = (m0 > m1) ? m1 : m0;
    mhi = (m0 > m1) ? m0 : m1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmf_pkg::S_CLEAR;
      mode <= mmf_pkg::MODE_PASS;
      q_noise <= 20'd6554;
      r_noise <= 20'd32768;
      clr_cnt <= '0;
      out_v <= 1'b0;
      ch <= '0;
      slot <= '0;
      fill <= '0;
      mslot <= '0;
      mfill <= '0;
      for (int i = 0; i < mmf_pkg::NCH; i++) begin
        sums[i] <= '0;
        est[i] <= mmf_pkg::KAL_EST_RESET;
        cov[i] <= mmf_pkg::KAL_COV_RESET;
        for (int j = 0; j < 3; j++) med[j][i] <= '0;
      end
    end else begin
      if (out_v && m_axis_tready) out_v <= 1'b0;
      if (cfg_fire && cfg_index == mmf_pkg::REG_Q) q_noise <= cfg_data;
      if (cfg_fire && cfg_index == mmf_pkg::REG_R) r_noise <= cfg_data;
      if (mode_wr) begin
        mode <= cfg_data[1:0];
        state <= mmf_pkg::S_CLEAR;
        clr_cnt <= '0;
        slot <= '0;
        fill <= '0;
        mslot <= '0;
        mfill <= '0;
        for (int i = 0; i < mmf_pkg::NCH; i++) begin
          sums[i] <= '0;
          est[i] <= mmf_pkg::KAL_EST_RESET;
          cov[i] <= mmf_pkg::KAL_COV_RESET;
          for (int j = 0; j < 3; j++) med[j][i] <= '0;
        end
      end else begin
        case (state)
          mmf_pkg::S_CLEAR: begin
            clr_cnt <= clr_cnt + 1'b1;
            if (clr_cnt == mmf_pkg::AVG_AW'(mmf_pkg::AVG_DEPTH - 1))
              state <= mmf_pkg::S_IDLE;
          end
          mmf_pkg::S_IDLE: begin
            if (in_fire) begin
              samp <= s_axis_tdata;
              ch <= '0;
              rdy <= 1'b1;
              state <= mmf_pkg::S_RD;
              if (mode == mmf_pkg::MODE_AVG) begin
                if (fill != 4'(mmf_pkg::AVG_WINDOW)) fill <= fill + 1'b1;
              end
              if (mode == mmf_pkg::MODE_MED) begin
                if (mfill != 2'd3) mfill <= mfill + 1'b1;
              end
            end
          end
          mmf_pkg::S_RD: begin
            case (mode)
              mmf_pkg::MODE_AVG: state <= mmf_pkg::S_AVG;
              mmf_pkg::MODE_KAL: begin
                p1 <= (p1_sum > 21'hFFFFF) ? 21'hFFFFF : p1_sum;
                state <= mmf_pkg::S_KP;
              end
              mmf_pkg::MODE_MED: begin
                med[mslot][ch] <= z;
                state <= mmf_pkg::S_NEXT;
              end
              default: begin
                res[ch] <= z;
                state <= mmf_pkg::S_NEXT;
              end
            endcase
          end
          mmf_pkg::S_AVG: begin
            sums[ch] <= sums[ch] - 18'(ram_rd) + 18'(z);
            dnum <= {18'(sums[ch] - 18'(ram_rd) + 18'(z)), 19'd0};
            dden <= 21'(fill);
            drem <= '0;
            dcnt <= 6'd18;
            state <= mmf_pkg::S_DIV;
          end
          mmf_pkg::S_DIV: begin
            if (rem_try[21]) drem <= {drem[19:0], dnum[36]};
            else drem <= rem_try[20:0];
            dnum <= {dnum[35:0], ~rem_try[21]};
            dcnt <= dcnt - 1'b1;
            if (dcnt == 6'd1) state <= mmf_pkg::S_KM2;
          end
          mmf_pkg::S_KP: begin
            dnum <= {p1, 16'd0};
            dden <= den_sum[20:0];
            drem <= '0;
            dcnt <= 6'd37;
            if (den_sum == 22'd0) begin
              kgain <= 17'd65536;
              state <= mmf_pkg::S_KM1;
            end else begin
              state <= mmf_pkg::S_KDIV;
            end
          end
          mmf_pkg::S_KDIV: begin
            if (rem_try[21]) drem <= {drem[19:0], dnum[36]};
            else drem <= rem_try[20:0];
            dnum <= {dnum[35:0], ~rem_try[21]};
            dcnt <= dcnt - 1'b1;
            if (dcnt == 6'd1) begin
              kgain <= {dnum[15:0], ~rem_try[21]};
              state <= mmf_pkg::S_KM1;
            end
          end
          mmf_pkg::S_KM1: begin
            diff <= 22'(signed'({2'b00, z, 8'd0})) - 22'(signed'({2'b00, est[ch]}));
            pcov <= 37'((17'd65536 - kgain) * p1);
            state <= mmf_pkg::S_KM2;
          end
          mmf_pkg::S_KM2: begin
            if (mode == mmf_pkg::MODE_KAL) begin
              prod <= signed'({23'd0, kgain}) * 40'(diff);
              cov[ch] <= pcov[35:16];
              state <= mmf_pkg::S_NEXT;
            end else begin
              res[ch] <= dnum[11:0];
              state <= mmf_pkg::S_NEXT;
            end
          end
          mmf_pkg::S_NEXT: begin
            if (mode == mmf_pkg::MODE_KAL) begin
              if (xnew < 0) begin
                est[ch] <= '0;
                res[ch] <= '0;
              end else if (xnew > 23'sh0FFFFF) begin
                est[ch] <= 20'hFFFFF;
                res[ch] <= 12'hFFF;
              end else begin
                est[ch] <= xnew[19:0];
                res[ch] <= xnew[19:8];
              end
            end
            if (mode == mmf_pkg::MODE_MED) begin
              res[ch] <= (mfill == 2'd3) ? ((m2 > mhi) ? mhi : ((m2 < mlo) ? mlo : m2))
                                         : 12'd0;
              rdy <= mfill == 2'd3;
            end
            if (ch == 3'(mmf_pkg::NCH - 1)) begin
              state <= mmf_pkg::S_OUT;
            end else begin
              ch <= ch + 1'b1;
              state <= mmf_pkg::S_RD;
            end
          end
          mmf_pkg::S_OUT: begin
            out_v <= 1'b1;
            state <= mmf_pkg::S_IDLE;
            if (mode == mmf_pkg::MODE_AVG) slot <= slot + 1'b1;
            if (mode == mmf_pkg::MODE_MED) mslot <= (mslot == 2'd2) ? 2'd0 : mslot + 1'b1;
          end
          default: state <= mmf_pkg::S_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    for (int i = 0; i < mmf_pkg::NCH; i++) m_axis_tdata[12*i +: 12] = res[i];
    m_axis_tuser = rdy;
  end

  `MMF_ASSERT_IMP(a_no_accept_busy, clk, rst, state != mmf_pkg::S_IDLE, !s_axis_tready)
  `MMF_ASSERT_NXT(a_out_after_done, clk, rst, state == mmf_pkg::S_OUT && !mode_wr, m_axis_tvalid)
  `MMF_ASSERT_IMP(a_ch_range, clk, rst, 1'b1, ch <= 3'(mmf_pkg::NCH - 1))
endmodule

FILE: bench/multi_mode_adc_channel_filter_tb.sv
// Testbench for the six-channel multi-mode ADC filter.
// Drives sample frames and register writes; a scoreboard class predicts each frame.
// Depends on mmf_pkg and the multi_mode_adc_channel_filter RTL.
`timescale 1ns / 1ps
module multi_mode_adc_channel_filter_tb;

  class filter_scoreboard;
    logic [1:0] mode;
    logic [19:0] q_noise, r_noise;
    logic [11:0] avg_hist [mmf_pkg::AVG_WINDOW][mmf_pkg::NCH];
    logic [17:0] avg_total [mmf_pkg::NCH];
    int unsigned avg_pos, avg_count;
    logic [11:0] med_hist [3][mmf_pkg::NCH];
    int unsigned med_pos, med_count;
    logic [19:0] est [mmf_pkg::NCH];
    logic [19:0] cov [mmf_pkg::NCH];
    logic [71:0] want_data [$];
    logic want_flag [$];
    int unsigned mismatches;

    function void clear_state();
      for (int c = 0; c < mmf_pkg::NCH; c++) begin
        for (int s = 0; s < mmf_pkg::AVG_WINDOW; s++) avg_hist[s][c] = '0;
        for (int s = 0; s < 3; s++) med_hist[s][c] = '0;
        avg_total[c] = '0;
        est[c] = mmf_pkg::KAL_EST_RESET;
        cov[c] = mmf_pkg::KAL_COV_RESET;
      end
      avg_pos = 0; avg_count = 0; med_pos = 0; med_count = 0;
    endfunction

    function void reset_all();
      mode = mmf_pkg::MODE_PASS; q_noise = 20'd6554; r_noise = 20'd32768; mismatches = 0;
      clear_state();
    endfunction

    function void write_reg(logic [1:0] idx, logic [19:0] val);
      if (idx == mmf_pkg::REG_MODE) begin
        mode = val[1:0];
        clear_state();
      end else if (idx == mmf_pkg::REG_Q) q_noise = val;
      else if (idx == mmf_pkg::REG_R) r_noise = val;
    endfunction

    function logic [11:0] kalman_track(int c, logic [11:0] z);
      longint unsigned p1, den, k, mag;
      longint x, diff, prod, corr;
      p1 = cov[c] + q_noise;
      if (p1 > 64'hFFFFF) p1 = 64'hFFFFF;
      den = p1 + r_noise;
      k = (den == 0) ? 64'd65536 : (p1 << 16) / den;
      x = est[c];
      diff = longint'({z, 8'h00}) - x;
      prod = longint'(k) * diff;
      if (prod >= 0) corr = prod >>> 16;
      else begin
        mag = -prod;
        corr = -longint'((mag + 64'hFFFF) >> 16);
      end
      x += corr;
      if (x < 0) x = 0;
      if (x > 64'hFFFFF) x = 64'hFFFFF;
      est[c] = x[19:0];
      cov[c] = 20'(((64'd65536 - k) * p1) >> 16);
      return est[c][19:8];
    endfunction

    function void note_frame(logic [71:0] raw);
      logic [11:0] s, a, b, m, o;
      logic [71:0] res;
      logic flag;
      res = '0;
      flag = 1'b1;
      if (mode == mmf_pkg::MODE_AVG) begin
        if (avg_count < mmf_pkg::AVG_WINDOW) avg_count++;
      end else if (mode == mmf_pkg::MODE_MED) begin
        if (med_count < 3) med_count++;
        if (med_count < 3) flag = 1'b0;
      end
      for (int c = 0; c < mmf_pkg::NCH; c++) begin
        s = raw[12*c +: 12];
        case (mode)
          mmf_pkg::MODE_AVG: begin
            avg_total[c] = avg_total[c] - avg_hist[avg_pos][c] + s;
            avg_hist[avg_pos][c] = s;
            o = 12'(avg_total[c] / avg_count);
          end
          mmf_pkg::MODE_MED: begin
            med_hist[med_pos][c] = s;
            a = med_hist[0][c]; b = med_hist[1][c]; m = med_hist[2][c];
            if (!flag) o = '0;
            else if ((a <= b && b <= m) || (m <= b && b <= a)) o = b;
            else if ((b <= a && a <= m) || (m <= a && a <= b)) o = a;
            else o = m;
          end
          mmf_pkg::MODE_KAL: o = kalman_track(c, s);
          default: o = s;
        endcase
        res[12*c +: 12] = o;
      end
      if (mode == mmf_pkg::MODE_AVG) avg_pos = (avg_pos + 1) % mmf_pkg::AVG_WINDOW;
      if (mode == mmf_pkg::MODE_MED) med_pos = (med_pos + 1) % 3;
      want_data.push_back(res);
      want_flag.push_back(flag);
    endfunction

    function void check_result(logic [71:0] got, logic got_flag);
      logic [71:0] w;
      logic wf;
      if (want_data.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      w = want_data.pop_front();
      wf = want_flag.pop_front();
      for (int c = 0; c < mmf_pkg::NCH; c++)
        if (got[12*c +: 12] !== w[12*c +: 12]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ch%0d expected %0d got %0d", c, w[12*c +: 12], got[12*c +: 12]);
        end
      if (got_flag !== wf) begin
        mismatches++;
        if (mismatches <= 10) $display("ready flag expected %b got %b", wf, got_flag);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [71:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;
  int send_idle = 0, recv_idle = 0;
  int unsigned cycles = 0;
  filter_scoreboard board;

  multi_mode_adc_channel_filter dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
    if (cycles > 2000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk)
    m_axis_tready <= ($urandom_range(99) >= recv_idle);

  task automatic send_frame(logic [71:0] raw);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= raw;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_frame(raw);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (board.want_data.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [19:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [71:0] rand_frame(int kind);
    logic [71:0] r;
    for (int c = 0; c < mmf_pkg::NCH; c++)
      case (kind)
        0: r[12*c +: 12] = 12'($urandom_range(4095));
        1: r[12*c +: 12] = ($urandom_range(1)) ? 12'hFFF : 12'h000;
        default: r[12*c +: 12] = 12'(2000 + $urandom_range(100));
      endcase
    return r;
  endfunction

  task automatic run_frames(int n);
    for (int i = 0; i < n; i++) send_frame(rand_frame($urandom_range(5) == 0 ? 1 : 0));
  endtask

  initial begin
    board = new();
    board.reset_all();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    send_idle = 8; recv_idle = 45;
    send_frame('0);
    send_frame({6{12'hFFF}});
    send_frame(72'h5A5_A5A_123_FED_800_7FF);
    for (int m = 1; m < 4; m++) begin
      drain();
      write_cfg(mmf_pkg::REG_MODE, 20'(m));
      send_frame({6{12'hFFF}});
      send_frame('0);
      send_frame({6{12'hFFF}});
      send_frame(72'h001_FFF_800_7FF_ABC_123);
      send_frame('0);
    end
    drain();
    write_cfg(mmf_pkg::REG_R, 20'd0);
    write_cfg(mmf_pkg::REG_Q, 20'd0);
    write_cfg(mmf_pkg::REG_MODE, {18'd0, mmf_pkg::MODE_KAL});
    send_frame({6{12'hFFF}});
    send_frame('0);
    drain();
    write_cfg(mmf_pkg::REG_Q, 20'hFFFFF);
    write_cfg(mmf_pkg::REG_R, 20'hFFFFF);
    send_frame({6{12'hFFF}});
    send_frame('0);
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin send_idle = 45; recv_idle = 8; end
      if (ph == 8) begin send_idle = 0; recv_idle = 0; end
      drain();
      write_cfg(mmf_pkg::REG_Q, ($urandom_range(3) == 0) ? 20'($urandom_range(20'hFFFFF))
                                                         : 20'($urandom_range(20000)));
      write_cfg(mmf_pkg::REG_R, ($urandom_range(3) == 0) ? 20'($urandom_range(20'hFFFFF))
                                                         : 20'(1 + $urandom_range(60000)));
      write_cfg(mmf_pkg::REG_MODE, 20'(ph % 4));
      run_frames(62);
    end
    drain();
    if (board.mismatches == 0 && board.want_data.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+src
src/mmf_pkg.sv
src/mmf_ram.sv
src/multi_mode_adc_channel_filter.sv
bench/multi_mode_adc_channel_filter_tb.sv
